// ===== rtl/core/trt_pkg.sv =====
// Package for the topic registry table: status codes, operation codes and shared types.
// It has no dependencies; trt_cell, topic_registry_table and trt_checker import it.
package trt_pkg;
	localparam logic [2:0] OP_ADD_REMOTE = 3'd0;
	localparam logic [2:0] OP_ADD_CAND   = 3'd1;
	localparam logic [2:0] OP_LOOKUP     = 3'd2;
	localparam logic [2:0] OP_ASSIGN     = 3'd3;
	localparam logic [2:0] OP_NAME_BY_ID = 3'd4;
	localparam logic [2:0] OP_LIST       = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_ASSIGNED  = 3'd3;
	localparam logic [2:0] ST_CANDIDATE = 3'd4;
	localparam logic [2:0] ST_ABSENT    = 3'd5;

	localparam int MAX_RESULTS = 32;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] id_out;
		logic [3:0]  slot_out;
		logic [7:0]  byte_out;
		logic        any_new;
		logic        run_last;
	} result_t;
endpackage

// ===== rtl/core/trt_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
// Depends on nothing; the payload type is a parameter.
interface trt_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/trt_cell.sv =====
// One table entry cell: name bytes, length, ID and local flag.
// Uses trt_pkg; compares one key byte per cycle and passes the byte on to its neighbor.
module trt_cell
	import trt_pkg::*;
#(
	parameter int NAME_BYTES = 32,
	parameter int LW = 6,
	parameter int BW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    key_in,
	input  logic          kv_in,
	input  logic [BW-1:0] kidx_in,
	output logic [7:0]    key_out,
	output logic          kv_out,
	output logic [BW-1:0] kidx_out,
	input  logic          cmp_clr,
	output logic          mism,
	input  logic          wr_name,
	input  logic [7:0]    wr_byte,
	input  logic [BW-1:0] wr_idx,
	input  logic          wr_len,
	input  logic [LW-1:0] len_val,
	input  logic          wr_id,
	input  logic [15:0]   id_val,
	input  logic          wr_flag,
	input  logic          flag_val,
	input  logic [BW-1:0] rd_idx,
	output logic [7:0]    rd_byte,
	output logic [LW-1:0] len,
	output logic [15:0]   id,
	output logic          flag
);
	logic [7:0]    name_q [NAME_BYTES];
	logic [LW-1:0] len_q;
	logic [15:0]   id_q;
	logic          flag_q;
	logic          mism_q;
	logic [7:0]    key_q;
	logic          kv_q;
	logic [BW-1:0] kidx_q;
	logic [LW-1:0] kidx_ext;

	assign kidx_ext = LW'(kidx_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			id_q   <= '0;
			flag_q <= 1'b0;
			mism_q <= 1'b0;
			kv_q   <= 1'b0;
			for (int i = 0; i < NAME_BYTES; i++) name_q[i] <= '0;
		end else begin
			kv_q <= kv_in;
			if (cmp_clr) mism_q <= 1'b0;
			else if (kv_in) begin
				if ((kidx_ext < len_q ? name_q[kidx_in] : 8'd0) != key_in) mism_q <= 1'b1;
			end
			if (wr_name) name_q[wr_idx] <= wr_byte;
			if (wr_len) len_q <= len_val;
			if (wr_id) id_q <= id_val;
			if (wr_flag) flag_q <= flag_val;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_in;
		kidx_q <= kidx_in;
	end

	assign key_out  = key_q;
	assign kv_out   = kv_q;
	assign kidx_out = kidx_q;
	assign mism     = mism_q | (len_q == '0);
	assign rd_byte  = (LW'(rd_idx) < len_q) ? name_q[rd_idx] : 8'd0;
	assign len      = len_q;
	assign id       = id_q;
	assign flag     = flag_q;
endmodule

// ===== rtl/core/topic_registry_table.sv =====
// Top level of the topic registry table: key buffer, sequencer and the row of entry cells.
// Uses trt_pkg, trt_if and trt_cell.
//
// Usage: input transactions on in_ch carry one name byte each for add remote, add candidate
// and lookup; the operation runs on the transaction with name_end set. Assign ids, name by id
// and list run on any transaction. Results leave on out_ch; run_last marks an operation's last.
// Name operations stream the key bytes down the cell row, one byte per cycle: feed of the key
// bytes and drain through the row, then a scan of the entries for a match, for adds a second
// scan for an empty slot, and a store of NAME_BYTES bytes when a name is written, then the
// result. Assign ids scans the row twice, then gives its result. Name by id scans for the id,
// then gives one result per name byte, one per cycle while the receiver is ready. List counts
// the entries to report in one pass, then visits one slot per cycle while the receiver is
// ready. Name bytes without name_end are only added to the key and give no result.
// One operation runs at a time; in_ch is not ready while one runs or while a result waits.
// At reset all entries are cleared at once and the key is empty.
// When the receiver stalls, the sequencer holds its result in the output register and waits.
module topic_registry_table
	import trt_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int NAME_BYTES = 32
) (
	input  logic clk,
	input  logic arst_n,
	trt_if.sink   in_ch,
	trt_if.source out_ch
);
	localparam int LW = $clog2(NAME_BYTES + 1);
	localparam int BW = $clog2(NAME_BYTES);
	localparam int EW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + NAME_BYTES + 2);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FEED  = 4'd1;
	localparam logic [3:0] S_DRAIN = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_EMPTY = 4'd4;
	localparam logic [3:0] S_STORE = 4'd5;
	localparam logic [3:0] S_MAX   = 4'd6;
	localparam logic [3:0] S_ASGN  = 4'd7;
	localparam logic [3:0] S_FIND  = 4'd8;
	localparam logic [3:0] S_BYTES = 4'd9;
	localparam logic [3:0] S_LIST  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_LCNT  = 4'd12;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  name_byte;
		logic        name_end;
		logic [15:0] topic_number;
		logic        local_only;
	} in_t;

	in_t in_d;
	assign in_d = in_ch.data;

	logic [3:0]    state_q, ret_q;
	logic [7:0]    key_q [NAME_BYTES];
	logic [LW-1:0] klen_q;
	logic [2:0]    op_q;
	logic [15:0]   num_q, max_q, lid_q;
	logic          lo_q, any_q, vout_q;
	logic [EW-1:0] e_q, hit_q;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] j_q;
	logic [5:0]    n_q;
	logic [5:0]    tot_q;
	logic          got_q;
	result_t       res_q;

	logic [7:0]    kb [ENTRIES+1];
	logic          kv [ENTRIES+1];
	logic [BW-1:0] ki [ENTRIES+1];
	logic [ENTRIES-1:0] mism_v, wn, wl, wi, wf;
	logic [7:0]    rdb [ENTRIES];
	logic [LW-1:0] lens [ENTRIES];
	logic [15:0]   ids [ENTRIES];
	logic          flags [ENTRIES];
	logic          cmp_clr, fval;
	logic [15:0]   idv;
	logic [LW-1:0] lenv;
	logic [7:0]    wbyte;

	assign kb[0] = key_q[j_q];
	assign kv[0] = (state_q == S_FEED);
	assign ki[0] = j_q;
	assign cmp_clr = (state_q == S_IDLE);
	assign wbyte = (LW'(j_q) < klen_q) ? key_q[j_q] : 8'd0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		trt_cell #(.NAME_BYTES(NAME_BYTES), .LW(LW), .BW(BW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.key_in(kb[g]), .kv_in(kv[g]), .kidx_in(ki[g]),
			.key_out(kb[g+1]), .kv_out(kv[g+1]), .kidx_out(ki[g+1]),
			.cmp_clr(cmp_clr), .mism(mism_v[g]),
			.wr_name(wn[g]), .wr_byte(wbyte), .wr_idx(j_q),
			.wr_len(wl[g]), .len_val(lenv), .wr_id(wi[g]), .id_val(idv),
			.wr_flag(wf[g]), .flag_val(fval), .rd_idx(j_q),
			.rd_byte(rdb[g]), .len(lens[g]), .id(ids[g]), .flag(flags[g])
		);
	end

	logic          cm, ce, cz;
	logic [15:0]   cid;
	logic [15:0]   nmax;
	assign cid  = ids[e_q];
	assign cm   = !mism_v[e_q];
	assign cz   = (cid == 16'd0);
	assign ce   = cz && (lens[e_q] == '0);
	assign nmax = max_q + 16'd1;

	always_comb begin
		wn = '0; wl = '0; wi = '0; wf = '0;
		idv = num_q; lenv = klen_q; fval = 1'b0;
		unique case (state_q)
			S_SCAN: if (op_q == OP_ADD_REMOTE && cm && cz) wi[e_q] = 1'b1;
			S_STORE: begin
				wn[hit_q] = 1'b1;
				if (cnt_q == '0) begin
					wl[hit_q] = 1'b1;
					wi[hit_q] = (op_q == OP_ADD_REMOTE);
				end
			end
			S_ASGN: if (cz && lens[e_q] != '0 && !vout_q) begin
				idv = nmax; wi[e_q] = 1'b1; wf[e_q] = 1'b1; fval = 1'b1;
			end
			S_LIST: if ((!vout_q || out_ch.ready) && !cz && (!lo_q || flags[e_q]) &&
				n_q < 6'(MAX_RESULTS))
				wf[e_q] = 1'b1;
			default: ;
		endcase
	end

	assign in_ch.ready  = (state_q == S_IDLE) && !vout_q;
	assign out_ch.valid = vout_q;
	assign out_ch.data  = res_q;

	function automatic result_t mk(logic [2:0] s, logic [15:0] i, logic [EW-1:0] sl,
		logic [7:0] b, logic a, logic l);
		result_t r;
		r.status = s; r.id_out = i; r.slot_out = 4'(sl); r.byte_out = b;
		r.any_new = a; r.run_last = l;
		return r;
	endfunction

	logic last_e;
	assign last_e = (e_q == EW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ret_q <= S_IDLE; klen_q <= '0; vout_q <= 1'b0;
			op_q <= '0; num_q <= '0; lo_q <= 1'b0; max_q <= '0; lid_q <= '0;
			any_q <= 1'b0; e_q <= '0; hit_q <= '0; cnt_q <= '0; j_q <= '0;
			n_q <= '0; tot_q <= '0; got_q <= 1'b0; res_q <= '0;
		end else begin
			if (vout_q && out_ch.ready) vout_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid && !vout_q) begin
					op_q <= in_d.operation; num_q <= in_d.topic_number; lo_q <= in_d.local_only;
					e_q <= '0; j_q <= '0; cnt_q <= '0; max_q <= '0; lid_q <= '0;
					any_q <= 1'b0; n_q <= '0; tot_q <= '0; got_q <= 1'b0; hit_q <= '0;
					if (in_d.operation <= OP_LOOKUP) begin
						if (klen_q < LW'(NAME_BYTES)) klen_q <= klen_q + 1'b1;
						if (in_d.name_end) state_q <= S_FEED;
					end else if (in_d.operation == OP_ASSIGN) state_q <= S_MAX;
					else if (in_d.operation == OP_NAME_BY_ID) state_q <= S_FIND;
					else if (in_d.operation == OP_LIST) state_q <= S_LCNT;
				end
				S_FEED: begin
					if (LW'(j_q) + 1'b1 >= klen_q) begin
						state_q <= S_DRAIN; cnt_q <= '0;
					end else j_q <= j_q + 1'b1;
				end
				S_DRAIN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(ENTRIES)) begin state_q <= S_SCAN; e_q <= '0; end
				end
				S_SCAN: begin
					if (op_q == OP_ADD_REMOTE && cm && cz) begin
						res_q <= mk(ST_OK, num_q, e_q, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
					end else if (op_q == OP_ADD_REMOTE && (cm || cid == num_q)) begin
						res_q <= mk(ST_EXISTS, cid, e_q, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
					end else if (cm && op_q == OP_ADD_CAND) begin
						res_q <= mk(ST_EXISTS, cid, e_q, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
					end else if (cm) begin
						res_q <= mk(cz ? ST_CANDIDATE : ST_ASSIGNED, cid, e_q, 8'd0, 1'b0, 1'b1);
						state_q <= S_OUT;
					end else if (last_e) begin
						e_q <= '0;
						if (op_q == OP_LOOKUP) begin
							res_q <= mk(ST_ABSENT, 16'd0, '0, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
						end else state_q <= S_EMPTY;
					end else e_q <= e_q + 1'b1;
				end
				S_EMPTY: begin
					if (ce) begin
						hit_q <= e_q; j_q <= '0; cnt_q <= CW'(NAME_BYTES - 1); state_q <= S_STORE;
						res_q <= mk(ST_OK, (op_q == OP_ADD_REMOTE) ? num_q : 16'd0, e_q,
							8'd0, 1'b0, 1'b1);
					end else if (last_e) begin
						res_q <= mk(ST_FULL, 16'd0, '0, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
					end else e_q <= e_q + 1'b1;
				end
				S_STORE: begin
					j_q <= j_q + 1'b1; cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_OUT;
				end
				S_MAX: begin
					if (cid > max_q) max_q <= cid;
					if (last_e) begin e_q <= '0; state_q <= S_ASGN; end
					else e_q <= e_q + 1'b1;
				end
				S_ASGN: begin
					if (cz && lens[e_q] != '0) begin
						max_q <= nmax; lid_q <= nmax; hit_q <= e_q; any_q <= 1'b1;
					end
					if (last_e) state_q <= S_OUT;
					else e_q <= e_q + 1'b1;
					if (last_e) begin
						if (cz && lens[e_q] != '0)
							res_q <= mk(ST_OK, nmax, e_q, 8'd0, 1'b1, 1'b1);
						else res_q <= mk(ST_OK, lid_q, any_q ? hit_q : '0, 8'd0, any_q, 1'b1);
					end
				end
				S_FIND: begin
					if (cid == num_q) begin
						if (lens[e_q] == '0) begin
							res_q <= mk(ST_ABSENT, 16'd0, '0, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
						end else begin hit_q <= e_q; j_q <= '0; state_q <= S_BYTES; end
					end else if (last_e) begin
						res_q <= mk(ST_ABSENT, 16'd0, '0, 8'd0, 1'b0, 1'b1); state_q <= S_OUT;
					end else e_q <= e_q + 1'b1;
				end
				S_BYTES: if (!vout_q || out_ch.ready) begin
					res_q <= mk((num_q != 16'd0) ? ST_ASSIGNED : ST_CANDIDATE, num_q, hit_q,
						rdb[hit_q], 1'b0, LW'(j_q) + 1'b1 == lens[hit_q]);
					vout_q <= 1'b1;
					if (LW'(j_q) + 1'b1 == lens[hit_q]) state_q <= S_IDLE;
					else j_q <= j_q + 1'b1;
				end
				S_LCNT: begin
					if (!cz && (!lo_q || flags[e_q]) && tot_q < 6'(MAX_RESULTS))
						tot_q <= tot_q + 6'd1;
					if (last_e) begin e_q <= '0; state_q <= S_LIST; end
					else e_q <= e_q + 1'b1;
				end
				S_LIST: if (!vout_q || out_ch.ready) begin
					if (!cz && (!lo_q || flags[e_q]) && n_q < 6'(MAX_RESULTS)) begin
						got_q <= 1'b1; n_q <= n_q + 1'b1; hit_q <= e_q;
						res_q <= mk(ST_OK, cid, e_q, 8'd0, 1'b0, n_q + 6'd1 == tot_q);
						vout_q <= 1'b1;
					end else vout_q <= 1'b0;
					if (last_e) state_q <= S_OUT;
					else e_q <= e_q + 1'b1;
				end
				S_OUT: if (!vout_q || out_ch.ready) begin
					vout_q <= 1'b1; state_q <= S_IDLE;
					if (op_q <= OP_LOOKUP) klen_q <= '0;
					if (op_q == OP_LIST) begin
						if (got_q || (!cz && (!lo_q || flags[e_q]) && 1'b0))
							vout_q <= 1'b0;
						if (!got_q) res_q <= mk(ST_ABSENT, 16'd0, '0, 8'd0, 1'b0, 1'b1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !vout_q && in_ch.valid && in_d.operation <= OP_LOOKUP &&
			klen_q < LW'(NAME_BYTES))
			key_q[BW'(klen_q)] <= in_d.name_byte;
	end

	logic unused_ret;
	assign unused_ret = (ret_q == S_IDLE);
endmodule

// ===== rtl/core/trt_checker.sv =====
// Port-level checker for topic_registry_table, bound to the top level.
// Uses trt_pkg for the status codes.
module trt_checker
	import trt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_ABSENT)
		else $error("status code out of range");
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_ABSENT |-> out_data.id_out == 16'd0
		&& out_data.run_last)
		else $error("not-found result carries data");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.run_last |-> !in_ready)
		else $error("input taken during a result run");
endmodule

bind topic_registry_table trt_checker u_trt_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
